/* sv/somt_pkg.sv */
// somt_pkg: shared types, constants and the neighborhood table for the SOM trainer.
// No dependencies.
`timescale 1ns / 1ps
package somt_pkg;
    localparam int ROWS_DEF     = 16;
    localparam int COLS_DEF     = 16;
    localparam int FEATURES_DEF = 3;
    localparam int HTAB_LEN     = 96;
    localparam int FW           = 8;
    localparam int LR_W         = 17;
    localparam logic [LR_W-1:0] LR_ONE = 17'd65536;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_TRAIN = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    localparam logic [0:0] CFG_MIN = 1'b0;
    localparam logic [0:0] CFG_MAX = 1'b1;

    // Q1.16 value of (20/23)^k, rounded from a 48-bit fractional recurrence.
    function automatic logic [16:0] htab_lookup(input logic [6:0] k);
        logic [63:0] p;
        logic [16:0] res;
        p   = 64'd1 << 48;
        res = '0;
        for (int i = 0; i < HTAB_LEN; i++) begin
            if (k == 7'(i)) res = 17'((p + (64'd1 << 31)) >> 32);
            p = (p * 64'd20) / 64'd23;
        end
        return res;
    endfunction

    // datapath commands from controller
    typedef struct packed {
        logic clr_best;   // start winner search
        logic scan_rd;    // issue memory read at scan address
        logic scan_cmp;   // compare distance of read data
        logic upd_rd;     // issue memory read for update pass
        logic upd_h;      // register lr*h and the read weights
        logic upd_mul;    // register products
        logic upd_wr;     // write updated neuron
        logic host_wr;    // host weight write
        logic host_rd;    // host weight read
        logic cap_read;   // capture read data to output
        logic cap_win;    // capture winner to output
        logic clr_out;    // zero result payload
    } somt_cmd_t;
endpackage

/* sv/self_organizing_map_trainer_top.sv */
// Kohonen self-organizing map trainer. A training beat makes two passes over the
// weight memory: one neuron is read per cycle in the winner search, then one
// neuron is read and written back per cycle in the update pass. One result beat per
// input beat; the next input is taken once the previous result has left.
// Depends on somt_pkg, somt_ctrl and somt_datapath.
`timescale 1ns / 1ps
module self_organizing_map_trainer_top
    import somt_pkg::*;
#(
    parameter int ROWS     = ROWS_DEF,
    parameter int COLS     = COLS_DEF,
    parameter int FEATURES = FEATURES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [0:0]      cfg_index,
    input  logic [7:0]      cfg_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      s_operation,
    input  logic [3:0]      s_row,
    input  logic [3:0]      s_col,
    input  logic [7:0]      s_feature_0,
    input  logic [7:0]      s_feature_1,
    input  logic [7:0]      s_feature_2,
    input  logic [16:0]     s_learning_rate,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [3:0]      m_winner_row,
    output logic [3:0]      m_winner_col,
    output logic [7:0]      m_read_feature_0,
    output logic [7:0]      m_read_feature_1,
    output logic [7:0]      m_read_feature_2
);
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

    logic [7:0] wmin_reg, wmax_reg;
    // hold the beat's fields for the whole operation
    logic [3:0]  row_reg, col_reg;
    logic [3*FW-1:0] samp_reg;
    logic [16:0] lr_reg;
    logic [FEATURES*FW-1:0] samp_live;
    logic [3*FW-1:0] s_all;
    logic [3*FW-1:0] feat;
    somt_cmd_t cmd;
    logic [RW-1:0] scan_r, upd_r;
    logic [CW-1:0] scan_c, upd_c;
    logic acc;

    assign acc   = s_valid && s_ready;
    assign s_all = {s_feature_2, s_feature_1, s_feature_0};
    assign samp_live = acc ? s_all[FEATURES*FW-1:0] : samp_reg[FEATURES*FW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wmin_reg <= 8'd56;
            wmax_reg <= 8'd255;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MIN: wmin_reg <= cfg_data;
                CFG_MAX: wmax_reg <= cfg_data;
                default: ;
            endcase
        end
        if (acc) begin
            row_reg <= s_row;
            col_reg <= s_col;
            samp_reg <= s_all;
            lr_reg <= s_learning_rate;
        end
    end

    somt_ctrl #(.ROWS(ROWS), .COLS(COLS)) u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready), .op(op_t'(s_operation)),
        .out_valid(m_valid), .out_ready(m_ready), .cmd,
        .scan_r, .scan_c, .upd_r, .upd_c
    );

    somt_datapath #(.ROWS(ROWS), .COLS(COLS), .FEATURES(FEATURES)) u_dp (
        .aclk, .cmd, .scan_r, .scan_c, .upd_r, .upd_c,
        .host_row(acc ? s_row : row_reg), .host_col(acc ? s_col : col_reg),
        .sample(samp_live), .lr_in(lr_reg), .wmin(wmin_reg), .wmax(wmax_reg),
        .out_wr(m_winner_row), .out_wc(m_winner_col), .out_feat(feat)
    );

    assign m_read_feature_0 = feat[7:0];
    assign m_read_feature_1 = feat[15:8];
    assign m_read_feature_2 = feat[23:16];
endmodule

/* sv/somt_datapath.sv */
// somt_datapath: weight memory, distance unit, winner tracking and update unit.
// Depends on somt_pkg; driven by somt_ctrl through somt_cmd_t.
`timescale 1ns / 1ps
module somt_datapath
    import somt_pkg::*;
#(
    parameter int ROWS     = ROWS_DEF,
    parameter int COLS     = COLS_DEF,
    parameter int FEATURES = FEATURES_DEF,
    localparam int DEPTH   = ROWS * COLS,
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int RW      = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int CW      = (COLS > 1) ? $clog2(COLS) : 1
) (
    input  logic                 aclk,
    input  somt_cmd_t            cmd,
    input  logic [RW-1:0]        scan_r,
    input  logic [CW-1:0]        scan_c,
    input  logic [RW-1:0]        upd_r,
    input  logic [CW-1:0]        upd_c,
    input  logic [3:0]           host_row,
    input  logic [3:0]           host_col,
    input  logic [FEATURES*FW-1:0] sample,
    input  logic [LR_W-1:0]      lr_in,
    input  logic [FW-1:0]        wmin,
    input  logic [FW-1:0]        wmax,
    output logic [3:0]           out_wr,
    output logic [3:0]           out_wc,
    output logic [3*FW-1:0]      out_feat
);
    localparam logic [16:0] DSQ_LIM = 17'(3 * HTAB_LEN);

    logic [FEATURES*FW-1:0] mem [DEPTH];
    logic [FEATURES*FW-1:0] rdata_reg;
    logic host_in;
    logic [AW-1:0] host_addr, scan_addr, upd_addr;
    logic [AW-1:0] wr_addr_reg, wr_addr_h_reg, wr_addr2_reg;

    assign host_in   = (32'(host_row) < ROWS) && (32'(host_col) < COLS);
    assign host_addr = AW'(32'(host_row) * COLS + 32'(host_col));
    assign scan_addr = AW'(32'(scan_r) * COLS + 32'(scan_c));
    assign upd_addr  = AW'(32'(upd_r) * COLS + 32'(upd_c));

    // distance of registered data
    logic [17:0] sq_dist;
    always_comb begin
        sq_dist = '0;
        for (int f = 0; f < FEATURES; f++) begin
            logic signed [9:0] e;
            e = $signed({2'b0, sample[f*FW +: FW]}) - $signed({2'b0, rdata_reg[f*FW +: FW]});
            sq_dist = sq_dist + 18'(e * e);
        end
    end

    logic [17:0] best_reg;
    logic        have_reg;
    logic [RW-1:0] br_reg, cmp_r_reg;
    logic [CW-1:0] bc_reg, cmp_c_reg;

    // update pipeline: rd -> h -> mul -> wr
    logic [RW-1:0] dr;
    logic [CW-1:0] dc;
    logic [16:0]   dsq;
    logic [19:0]   kprod;
    logic [6:0]    kk;
    logic [16:0]   hval;
    always_comb begin
        dr  = (upd_r > br_reg) ? upd_r - br_reg : br_reg - upd_r;
        dc  = (upd_c > bc_reg) ? upd_c - bc_reg : bc_reg - upd_c;
        dsq = 17'(32'(dr) * 32'(dr) + 32'(dc) * 32'(dc) + 2);
        // floor(dsq / 3) by reciprocal multiply, exact below the table limit
        kprod = 20'(dsq[8:0]) * 20'd683;
        kk  = (dsq >= DSQ_LIM) ? 7'd127 : kprod[17:11];
        hval = (kk == 7'd127) ? 17'd0 : htab_lookup(kk);
    end

    logic [16:0] h_reg;
    logic [33:0] lrh_reg;
    logic [LR_W-1:0] lr_sat;
    assign lr_sat = (lr_in > LR_ONE) ? LR_ONE : lr_in;
    logic [FEATURES*FW-1:0] w2_reg, w3_reg;
    logic signed [44:0] prod_reg [FEATURES];
    logic signed [44:0] prod_next [FEATURES];
    logic [FEATURES*FW-1:0] newv;

    always_comb begin
        for (int f = 0; f < FEATURES; f++) begin
            logic signed [9:0] dw;
            dw = $signed({2'b0, sample[f*FW +: FW]}) - $signed({2'b0, w2_reg[f*FW +: FW]});
            prod_next[f] = 45'(dw) * 45'($signed({1'b0, lrh_reg}));
        end
    end

    always_comb begin
        for (int f = 0; f < FEATURES; f++) begin
            logic signed [45:0] t;
            logic [13:0] v;
            t = $signed({6'b0, w3_reg[f*FW +: FW], 32'b0}) + 46'(prod_reg[f]);
            v = (t < 0) ? 14'd0 : 14'(t >>> 32);
            if (v > 14'(wmax)) v = 14'(wmax);
            if (v < 14'(wmin)) v = 14'(wmin);
            newv[f*FW +: FW] = v[FW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.host_wr && host_in) mem[host_addr] <= sample;
        if (cmd.upd_wr) mem[wr_addr2_reg] <= newv;
        if (cmd.host_rd) rdata_reg <= mem[host_addr];
        else if (cmd.scan_rd) rdata_reg <= mem[scan_addr];
        else if (cmd.upd_rd) rdata_reg <= mem[upd_addr];
        if (cmd.scan_rd) begin
            cmp_r_reg <= scan_r;
            cmp_c_reg <= scan_c;
        end
        if (cmd.upd_rd) wr_addr_reg <= upd_addr;
        if (cmd.clr_best) have_reg <= 1'b0;
        else if (cmd.scan_cmp && (!have_reg || sq_dist < best_reg)) begin
            have_reg <= 1'b1;
            best_reg <= sq_dist;
            br_reg   <= cmp_r_reg;
            bc_reg   <= cmp_c_reg;
        end
        if (cmd.upd_rd) h_reg <= hval;
        if (cmd.upd_h) begin
            lrh_reg <= 34'(lr_sat) * 34'(h_reg);
            w2_reg  <= rdata_reg;
            wr_addr_h_reg <= wr_addr_reg;
        end
        if (cmd.upd_mul) begin
            wr_addr2_reg <= wr_addr_h_reg;
            w3_reg <= w2_reg;
            for (int f = 0; f < FEATURES; f++)
                prod_reg[f] <= prod_next[f];
        end
        if (cmd.clr_out) begin
            out_wr <= '0; out_wc <= '0; out_feat <= '0;
        end else if (cmd.cap_read) begin
            out_feat <= '0;
            if (host_in) out_feat[FEATURES*FW-1:0] <= rdata_reg;
        end else if (cmd.cap_win) begin
            out_wr <= 4'(br_reg);
            out_wc <= 4'(bc_reg);
        end
    end
endmodule

/* sv/somt_ctrl.sv */
// somt_ctrl: sequencer for write, read and two-pass training.
// Depends on somt_pkg; drives somt_datapath.
`timescale 1ns / 1ps
module somt_ctrl
    import somt_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF,
    localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int CW  = (COLS > 1) ? $clog2(COLS) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  op_t           op,
    output logic          out_valid,
    input  logic          out_ready,
    output somt_cmd_t     cmd,
    output logic [RW-1:0] scan_r,
    output logic [CW-1:0] scan_c,
    output logic [RW-1:0] upd_r,
    output logic [CW-1:0] upd_c
);
    typedef enum logic [2:0] {S_IDLE, S_READ, S_SCAN, S_UPD, S_DONE} state_t;
    state_t state_reg;
    logic [RW-1:0] r_reg;
    logic [CW-1:0] c_reg;
    logic [2:0] pipe_reg;   // valid bits of cmp/h, mul and write stages
    logic issue_reg;
    logic out_valid_reg;

    logic last;
    assign last = (r_reg == RW'(ROWS - 1)) && (c_reg == CW'(COLS - 1));
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign scan_r = r_reg;
    assign scan_c = c_reg;
    assign upd_r = r_reg;
    assign upd_c = c_reg;

    always_comb begin
        cmd = '0;
        cmd.host_wr  = (state_reg == S_IDLE) && in_valid && in_ready && op == OP_WRITE;
        cmd.host_rd  = (state_reg == S_IDLE) && in_valid && in_ready && op == OP_READ;
        cmd.clr_out  = (state_reg == S_IDLE) && in_valid && in_ready;
        cmd.clr_best = cmd.clr_out && op == OP_TRAIN;
        cmd.cap_read = state_reg == S_READ;
        cmd.scan_rd  = state_reg == S_SCAN && issue_reg;
        cmd.scan_cmp = state_reg == S_SCAN && pipe_reg[0];
        cmd.upd_rd   = state_reg == S_UPD && issue_reg;
        cmd.upd_h    = state_reg == S_UPD && pipe_reg[0];
        cmd.upd_mul  = state_reg == S_UPD && pipe_reg[1];
        cmd.upd_wr   = state_reg == S_UPD && pipe_reg[2];
        cmd.cap_win  = state_reg == S_DONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            pipe_reg <= '0;
            issue_reg <= 1'b0;
            r_reg <= '0;
            c_reg <= '0;
        end else begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid && in_ready) begin
                        r_reg <= '0;
                        c_reg <= '0;
                        pipe_reg <= '0;
                        priority if (op == OP_TRAIN) begin
                            state_reg <= S_SCAN;
                            issue_reg <= 1'b1;
                        end else if (op == OP_READ) begin
                            state_reg <= S_READ;
                        end else begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                S_READ: begin
                    state_reg <= S_IDLE;
                    out_valid_reg <= 1'b1;
                end
                S_SCAN: begin
                    pipe_reg <= {2'b0, issue_reg};
                    if (issue_reg) begin
                        if (last) issue_reg <= 1'b0;
                        else if (c_reg == CW'(COLS - 1)) begin
                            c_reg <= '0;
                            r_reg <= r_reg + 1'b1;
                        end else c_reg <= c_reg + 1'b1;
                    end else if (!pipe_reg[0]) begin
                        state_reg <= S_UPD;
                        issue_reg <= 1'b1;
                        r_reg <= '0;
                        c_reg <= '0;
                    end
                end
                S_UPD: begin
                    // the write of a neuron lands before any later read of it
                    pipe_reg <= {pipe_reg[1:0], issue_reg};
                    if (issue_reg) begin
                        if (last) issue_reg <= 1'b0;
                        else if (c_reg == CW'(COLS - 1)) begin
                            c_reg <= '0;
                            r_reg <= r_reg + 1'b1;
                        end else c_reg <= c_reg + 1'b1;
                    end else if (pipe_reg == 3'b0) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    state_reg <= S_IDLE;
                    out_valid_reg <= 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench for the self-organizing map trainer.
// Directed table, grid fill and random phases, checked against typed answers or a built-in predictor.
// Depends on somt_pkg and self_organizing_map_trainer_top.
`timescale 1ns / 1ps
module tb_top
    import somt_pkg::*;
;

    localparam int GRID     = 16;
    localparam int CELLS    = GRID * GRID;
    localparam int WD_LIMIT = 20000;  // longer than one training beat plus stalls

    // One input beat and its result fields.
    typedef struct {
        op_t         op;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [7:0]  feat [3];
        logic [16:0] rate;
    } som_item_t;

    typedef struct {
        logic [3:0] win_row;
        logic [3:0] win_col;
        logic [7:0] rd [3];
    } som_result_t;

    // A row of the directed table: `fixed` marks a result typed in by hand.
    typedef struct {
        som_item_t   item;
        bit          fixed;
        som_result_t res;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = CFG_MIN;
    logic [7:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = OP_NOP;
    logic [3:0]  s_row = '0;
    logic [3:0]  s_col = '0;
    logic [7:0]  s_feature_0 = '0;
    logic [7:0]  s_feature_1 = '0;
    logic [7:0]  s_feature_2 = '0;
    logic [16:0] s_learning_rate = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_winner_row;
    logic [3:0]  m_winner_col;
    logic [7:0]  m_read_feature_0;
    logic [7:0]  m_read_feature_1;
    logic [7:0]  m_read_feature_2;

    self_organizing_map_trainer_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_row           (s_row),
        .s_col           (s_col),
        .s_feature_0     (s_feature_0),
        .s_feature_1     (s_feature_1),
        .s_feature_2     (s_feature_2),
        .s_learning_rate (s_learning_rate),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_winner_row    (m_winner_row),
        .m_winner_col    (m_winner_col),
        .m_read_feature_0(m_read_feature_0),
        .m_read_feature_1(m_read_feature_1),
        .m_read_feature_2(m_read_feature_2)
    );

    always #2 aclk = ~aclk;

    // Shadow of the map and the clamp registers.
    logic [7:0]  shadow_w [CELLS][3];
    logic [7:0]  clamp_lo = 8'd56;
    logic [7:0]  clamp_hi = 8'd255;
    logic [16:0] neigh_tab [96];

    som_result_t pending_results [$];
    int          errors = 0;
    int          tx_idle_pct = 6;
    int          rx_idle_pct = 63;
    int          quiet_cycles = 0;

    task automatic report(input string what, input int got, input int want);
        $display("ERROR %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Q1.16 (20/23)^k from a 48-bit fractional recurrence.
    function automatic void build_neigh_tab();
        logic [63:0] p;
        p = 64'd1 << 48;
        for (int k = 0; k < 96; k++) begin
            neigh_tab[k] = 17'((p + (64'd1 << 31)) >> 32);
            p = (p * 64'd20) / 64'd23;
        end
    endfunction

    function automatic logic [7:0] pull_weight(input logic [7:0] w, input logic [7:0] s,
                                               input longint lr, input longint h);
        longint diff;
        longint t;
        longint v;
        diff = longint'(s) - longint'(w);
        t = (longint'(w) <<< 32) + diff * (lr * h);
        v = (t < 0) ? 0 : (t >>> 32);
        if (v > clamp_hi) v = clamp_hi;
        if (v < clamp_lo) v = clamp_lo;
        return 8'(v);
    endfunction

    // Apply one beat to the shadow map and return the result it must produce.
    function automatic som_result_t map_outcome(input som_item_t it);
        som_result_t r;
        int unsigned best;
        int unsigned d;
        int          e;
        int          br;
        int          bc;
        int          dr;
        int          dc;
        int          k;
        bit          have;
        longint      lr;
        longint      h;
        r.win_row = '0;
        r.win_col = '0;
        r.rd = '{default: 8'd0};
        best = 0; br = 0; bc = 0; have = 0;
        case (it.op)
            OP_WRITE: begin
                for (int f = 0; f < 3; f++) shadow_w[it.row * GRID + it.col][f] = it.feat[f];
            end
            OP_READ: begin
                for (int f = 0; f < 3; f++) r.rd[f] = shadow_w[it.row * GRID + it.col][f];
            end
            OP_TRAIN: begin
                lr = (it.rate > LR_ONE) ? 65536 : longint'(it.rate);
                for (int i = 0; i < GRID; i++) begin
                    for (int j = 0; j < GRID; j++) begin
                        d = 0;
                        for (int f = 0; f < 3; f++) begin
                            e = int'(it.feat[f]) - int'(shadow_w[i * GRID + j][f]);
                            d += e * e;
                        end
                        if (!have || d < best) begin
                            have = 1; best = d; br = i; bc = j;
                        end
                    end
                end
                for (int i = 0; i < GRID; i++) begin
                    for (int j = 0; j < GRID; j++) begin
                        dr = (i > br) ? i - br : br - i;
                        dc = (j > bc) ? j - bc : bc - j;
                        k = (dr * dr + dc * dc + 2) / 3;
                        h = (k < 96) ? longint'(neigh_tab[k]) : 0;
                        for (int f = 0; f < 3; f++)
                            shadow_w[i * GRID + j][f] =
                                pull_weight(shadow_w[i * GRID + j][f], it.feat[f], lr, h);
                    end
                end
                r.win_row = 4'(br);
                r.win_col = 4'(bc);
            end
            default: ;
        endcase
        return r;
    endfunction

    // Present one beat; keep valid high across back-to-back beats.
    task automatic send_beat(input som_item_t it, input bit fixed, input som_result_t want);
        int gap;
        som_result_t pred;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= it.op;
        s_row           <= it.row;
        s_col           <= it.col;
        s_feature_0     <= it.feat[0];
        s_feature_1     <= it.feat[1];
        s_feature_2     <= it.feat[2];
        s_learning_rate <= it.rate;
        do @(posedge aclk); while (!s_ready);
        // predictor always advances, even when the table carries the answer
        pred = map_outcome(it);
        pending_results.push_back(fixed ? want : pred);
    endtask

    // Drop valid and hold until every result has drained.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_MIN) clamp_lo = val; else clamp_hi = val;
        @(posedge aclk);
    endtask

    function automatic som_item_t mk_item(input op_t op, input int row, input int col,
                                          input int f0, input int f1, input int f2,
                                          input int rate);
        som_item_t it;
        it.op = op; it.row = 4'(row); it.col = 4'(col);
        it.feat[0] = 8'(f0); it.feat[1] = 8'(f1); it.feat[2] = 8'(f2);
        it.rate = 17'(rate);
        return it;
    endfunction

    function automatic som_result_t mk_res(input int wr, input int wc,
                                           input int r0, input int r1, input int r2);
        som_result_t r;
        r.win_row = 4'(wr); r.win_col = 4'(wc);
        r.rd[0] = 8'(r0); r.rd[1] = 8'(r1); r.rd[2] = 8'(r2);
        return r;
    endfunction

    function automatic logic [7:0] rand_feat();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [16:0] rand_rate();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return LR_ONE;
            2: return 17'($urandom_range(131071, 65537));  // saturates to one
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    // Random beat: training dominates, reads and writes hit any cell (all written).
    function automatic som_item_t rand_item();
        som_item_t it;
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) it.op = OP_TRAIN;
        else if (pick < 68) it.op = OP_WRITE;
        else if (pick < 95) it.op = OP_READ;
        else it.op = OP_NOP;
        it.row = 4'($urandom_range(15));
        it.col = 4'($urandom_range(15));
        for (int f = 0; f < 3; f++) it.feat[f] = rand_feat();
        it.rate = rand_rate();
        return it;
    endfunction

    // Receiver: stall at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Check each result beat against the oldest expectation.
    always @(posedge aclk) begin
        som_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected result beat", 0, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_winner_row !== want.win_row)
                    report("winner_row", m_winner_row, want.win_row);
                if (m_winner_col !== want.win_col)
                    report("winner_col", m_winner_col, want.win_col);
                if (m_read_feature_0 !== want.rd[0])
                    report("read_feature_0", m_read_feature_0, want.rd[0]);
                if (m_read_feature_1 !== want.rd[1])
                    report("read_feature_1", m_read_feature_1, want.rd[1]);
                if (m_read_feature_2 !== want.rd[2])
                    report("read_feature_2", m_read_feature_2, want.rd[2]);
            end
        end
    end

    // Watchdog: end the run after too long with no beat on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WD_LIMIT) begin
            $display("self_organizing_map_trainer_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        dir_row_t    dir_rows [$];
        som_result_t none;
        int          tx_pct [3];
        int          rx_pct [3];
        logic [7:0]  lo_set [3];
        logic [7:0]  hi_set [3];

        none = mk_res(0, 0, 0, 0, 0);
        tx_pct = '{6, 63, 0};
        rx_pct = '{63, 6, 0};
        lo_set = '{8'd0, 8'd255, 8'd90};
        hi_set = '{8'd255, 8'd0, 8'd200};
        build_neigh_tab();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes of the data, write, read and no-op, typed answers where obvious.
        dir_rows.push_back('{mk_item(OP_WRITE, 0, 0, 255, 255, 255, 0), 1, none});
        dir_rows.push_back('{mk_item(OP_WRITE, 15, 15, 0, 0, 0, 131071), 1, none});
        dir_rows.push_back('{mk_item(OP_WRITE, 3, 12, 170, 85, 15, 65536), 1, none});
        dir_rows.push_back('{mk_item(OP_READ, 0, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 255, 255, 255)});
        dir_rows.push_back('{mk_item(OP_READ, 15, 15, 255, 255, 255, 131071), 1, none});
        dir_rows.push_back('{mk_item(OP_READ, 3, 12, 1, 2, 3, 4), 1, mk_res(0, 0, 170, 85, 15)});
        dir_rows.push_back('{mk_item(OP_NOP, 15, 15, 255, 255, 255, 131071), 1, none});
        dir_rows.push_back('{mk_item(OP_NOP, 0, 0, 0, 0, 0, 0), 1, none});
        dir_rows.push_back('{mk_item(OP_WRITE, 0, 0, 7, 9, 11, 0), 1, none});
        dir_rows.push_back('{mk_item(OP_READ, 0, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 7, 9, 11)});
        foreach (dir_rows[i]) send_beat(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].res);

        // Fill every cell so training never touches an unwritten neuron.
        for (int c = 0; c < CELLS; c++)
            send_beat(mk_item(OP_WRITE, c / GRID, c % GRID, $urandom_range(255),
                              $urandom_range(255), $urandom_range(255), 0), 0, none);

        // Directed training: zero rate, full rate, saturated rate, extreme samples.
        dir_rows.delete();
        dir_rows.push_back('{mk_item(OP_TRAIN, 0, 0, 128, 128, 128, 0), 0, none});
        dir_rows.push_back('{mk_item(OP_TRAIN, 0, 0, 0, 0, 0, 65536), 0, none});
        dir_rows.push_back('{mk_item(OP_TRAIN, 0, 0, 255, 255, 255, 131071), 0, none});
        dir_rows.push_back('{mk_item(OP_TRAIN, 0, 0, 255, 0, 255, 65537), 0, none});
        dir_rows.push_back('{mk_item(OP_TRAIN, 0, 0, 40, 200, 90, 30000), 0, none});
        dir_rows.push_back('{mk_item(OP_READ, 15, 0, 0, 0, 0, 0), 0, none});
        dir_rows.push_back('{mk_item(OP_READ, 0, 15, 0, 0, 0, 0), 0, none});
        foreach (dir_rows[i]) send_beat(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].res);

        // Random phases: new clamp bounds and idle pattern each, min above max in one.
        for (int ph = 0; ph < 3; ph++) begin
            drain();
            write_reg(CFG_MIN, lo_set[ph]);
            write_reg(CFG_MAX, hi_set[ph]);
            tx_idle_pct = tx_pct[ph];
            rx_idle_pct = rx_pct[ph];
            for (int n = 0; n < 285; n++) begin
                if (n == 120) drain();  // hold the sender until the block is empty
                send_beat(rand_item(), 0, none);
            end
        end

        drain();
        repeat (30) @(posedge aclk);
        if (errors == 0) begin
            $display("self_organizing_map_trainer_top: match");
        end else begin
            $display("self_organizing_map_trainer_top: mismatch");
        end
        $finish;
    end
endmodule

/* filelist.f */
sv/somt_pkg.sv
sv/somt_datapath.sv
sv/somt_ctrl.sv
sv/self_organizing_map_trainer_top.sv
tb/tb_top.sv
